[rtl/clcd_pkg.sv]
// Shared types, constants and tables for the character LCD nibble interface.
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

    localparam int NUM_LINES   = 4;
    localparam int LINE_LENGTH = 20;
    localparam int INIT_LEN    = 7;
    localparam int TICK_W      = 16;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_CMD    = 2'd1,
        REQ_DATA   = 2'd2,
        REQ_CURSOR = 2'd3
    } t_req_kind;

    typedef enum logic [0:0] {
        CFG_PULSE_TICKS = 1'b0,
        CFG_GAP_TICKS   = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PULSE,
        ST_PUT,
        ST_GAP
    } t_state;

    // Control from the sequencer to the tick counter.
    typedef struct packed {
        logic              load;
        logic [TICK_W-1:0] value;
    } t_tick_ctl;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h08;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h06;
            3'd6:    b = 8'h0F;
            default: b = 8'h0F;
        endcase
        return b;
    endfunction

    function automatic logic [6:0] line_base(input logic [1:0] line);
        logic [6:0] b;
        unique case (line)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h14;
            default: b = 7'h54;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/clcd_tick.sv]
// Down counter that times enable pulses and settle gaps in ticks.
`timescale 1ns / 1ps
`default_nettype none

module clcd_tick
    import clcd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_tick_ctl i_ctl,
    output logic           o_done
);

    logic [TICK_W-1:0] r_count;
    logic [TICK_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_ctl.load) begin
            n_count = i_ctl.value;
        end else if (r_count != '0) begin
            n_count = r_count - TICK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_done = (r_count == '0);

endmodule

`default_nettype wire

[rtl/char_lcd_nibble_interface.sv]
// Top level: request sequencer driving a character LCD over a 4-bit bus.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per beat on the slave side (init sequence, command byte,
// data byte or set cursor) and returns one beat per enable strobe on the
// master side: register select in tuser, the nibble and a gap flag in tdata,
// tlast on the final strobe of the request. Bytes go out high nibble first.
// A set-cursor request with line above 3 or column above 19 returns nothing.
// Each strobe is timed by pulse_ticks in the shared tick counter, after
// which its beat is posted; the second strobe of a byte is followed by a
// settle wait timed by gap_ticks. Init sends the seven bytes of its
// sequence and the other kinds one byte. A stall on the master side
// stretches this: a beat waits in the output register, and the sequencer
// holds until that register is free. The slave side is ready only while no
// request is in progress. Config writes are registered.
module char_lcd_nibble_interface
    import clcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] byte_value, [9:8] display_line,
                                             // [14:10] column, [15] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // strobe channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [3:0] nibble, [4] gap_after, [7:5] zero
    output logic             m_axis_tuser,   // [0] reg_select
    output logic             m_axis_tlast,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // config registers
    logic [TICK_W-1:0] r_pulse_ticks;
    logic [TICK_W-1:0] r_gap_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks <= TICK_W'(1);
            r_gap_ticks   <= TICK_W'(5);
        end else if (i_cfg_we && i_cfg_index[1] == 1'b0) begin
            unique case (t_cfg_reg'(i_cfg_index[0]))
                CFG_PULSE_TICKS: r_pulse_ticks <= i_cfg_data;
                CFG_GAP_TICKS:   r_gap_ticks   <= i_cfg_data;
                default:         r_pulse_ticks <= r_pulse_ticks;
            endcase
        end
    end

    // request fields
    t_req_kind  w_kind;
    logic [7:0] w_in_byte;
    logic [1:0] w_in_line;
    logic [4:0] w_in_col;

    assign w_kind    = t_req_kind'(s_axis_tuser);
    assign w_in_byte = s_axis_tdata[7:0];
    assign w_in_line = s_axis_tdata[9:8];
    assign w_in_col  = s_axis_tdata[14:10];

    // cursor request: range check and DDRAM address
    logic       w_cursor_ok;
    logic [7:0] w_addr_sum;
    logic [7:0] w_cursor_cmd;

    assign w_cursor_ok  = (32'(w_in_line) < NUM_LINES) && (32'(w_in_col) < LINE_LENGTH);
    assign w_addr_sum   = {1'b0, line_base(w_in_line)} + {3'b000, w_in_col};
    assign w_cursor_cmd = CMD_SET_DDRAM | {1'b0, w_addr_sum[6:0]};

    // sequencer state
    t_state     r_state, n_state;
    logic [2:0] r_idx, n_idx;       // init byte index
    logic       r_half, n_half;     // 0 high nibble, 1 low nibble
    logic       r_init, n_init;     // running the init sequence
    logic       r_rs, n_rs;
    logic [7:0] r_byte, n_byte;

    // output register
    logic       r_out_valid, n_out_valid;
    logic       r_out_rs, n_out_rs;
    logic [3:0] r_out_nib, n_out_nib;
    logic       r_out_gap, n_out_gap;
    logic       r_out_last, n_out_last;

    t_tick_ctl  w_tick;
    logic       w_tick_done;
    logic       w_accept;
    logic       w_start;
    logic       w_out_free;
    logic       w_last_byte;

    clcd_tick u_tick (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_tick),
        .o_done (w_tick_done)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_accept && (w_kind != REQ_CURSOR || w_cursor_ok);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_last_byte   = !r_init || (r_idx == 3'(INIT_LEN - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_PULSE;
                end
            end
            ST_PULSE: begin
                if (w_tick_done) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (w_out_free) begin
                    n_state = r_half ? ST_GAP : ST_PULSE;
                end
            end
            ST_GAP: begin
                if (w_tick_done) begin
                    n_state = w_last_byte ? ST_IDLE : ST_PULSE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx       = r_idx;
        n_half      = r_half;
        n_init      = r_init;
        n_rs        = r_rs;
        n_byte      = r_byte;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_rs    = r_out_rs;
        n_out_nib   = r_out_nib;
        n_out_gap   = r_out_gap;
        n_out_last  = r_out_last;
        w_tick      = '{load: 1'b0, value: r_pulse_ticks};

        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    w_tick.load = 1'b1;
                    n_idx       = '0;
                    n_half      = 1'b0;
                    n_init      = (w_kind == REQ_INIT);
                    n_rs        = (w_kind == REQ_DATA);
                    case (w_kind) inside
                        REQ_INIT:           n_byte = init_byte(3'd0);
                        REQ_CMD, REQ_DATA:  n_byte = w_in_byte;
                        default:            n_byte = w_cursor_cmd;
                    endcase
                end
            end
            ST_PUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = r_rs;
                    n_out_nib   = r_half ? r_byte[3:0] : r_byte[7:4];
                    n_out_gap   = r_half;
                    n_out_last  = r_half && w_last_byte;
                    w_tick.load = 1'b1;
                    w_tick.value = r_half ? r_gap_ticks : r_pulse_ticks;
                    n_half      = 1'b1;
                end
            end
            ST_GAP: begin
                if (w_tick_done && !w_last_byte) begin
                    w_tick.load = 1'b1;
                    n_idx       = r_idx + 3'd1;
                    n_half      = 1'b0;
                    n_byte      = init_byte(r_idx + 3'd1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_half      <= 1'b0;
            r_init      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_half      <= n_half;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rs       <= n_rs;
        r_byte     <= n_byte;
        r_out_rs   <= n_out_rs;
        r_out_nib  <= n_out_nib;
        r_out_gap  <= n_out_gap;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_gap, r_out_nib};
    assign m_axis_tuser  = r_out_rs;
    assign m_axis_tlast  = r_out_last;

    // checks
    a_last_has_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[4])
        else $error("final strobe without settle gap");

    a_put_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT && r_out_valid && !m_axis_tready) |=> (r_state == ST_PUT))
        else $error("strobe posted over a pending beat");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= 3'(INIT_LEN - 1)))
        else $error("init index past sequence end");

    a_bad_cursor_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == REQ_CURSOR && !w_cursor_ok) |=> (r_state == ST_IDLE))
        else $error("out-of-range cursor request started strobes");

endmodule

`default_nettype wire
